[rtl/due_date_priority_queue_defines.svh]
// Assertion macros used by the checker file of the due date priority queue.
`ifndef DUE_DATE_PRIORITY_QUEUE_DEFINES_SVH
`define DUE_DATE_PRIORITY_QUEUE_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define DDPQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ddpq check failed");

// Condition must hold in the cycle after the trigger.
`define DDPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ddpq check failed");

`endif

[rtl/ddpq_pkg.sv]
// Types, codes and the rank compare shared by the due date priority queue.
package ddpq_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int COUNT_W          = 5;

  // operation codes (in_tuser)
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // one queue entry, year in the lowest bits
  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] points;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } entry_t;

  // result word on out_tdata, status in the lowest bits
  typedef struct packed {
    logic [1:0]         pad;
    entry_t             head;
    logic [COUNT_W-1:0] count;
    logic [1:0]         status;
  } out_data_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

  // true when a ranks strictly above b
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic r;
    if (a.year != b.year)        r = a.year < b.year;
    else if (a.month != b.month) r = a.month < b.month;
    else if (a.day != b.day)     r = a.day < b.day;
    else                         r = a.points > b.points;
    return r;
  endfunction

endpackage

[rtl/due_date_priority_queue.sv]
// Top level of the due date priority queue: cell chain, count and result register.
//
// Usage:
//   Requests arrive on in_*: in_tuser selects the operation (0 enqueue,
//   1 dequeue), in_tdata carries the entry (year, month, day, points, tag).
//   Entries are kept sorted in a chain of CAPACITY cells: earlier date first,
//   more points first on equal dates, arrival order on equal keys.
//   Each request yields one result on out_*: status, count after the
//   request and the new head entry; out_tuser flags a non-empty queue, and
//   the head fields read zero when it is clear.
//   The result is valid in the cycle after the request is taken.
//   Throughput: one request per cycle while out_tready is high; every cell
//   compares and shifts in the same cycle, whatever the chain length.
//   A dequeue on an empty queue or an enqueue on a full one leaves the
//   queue as it was and reports it in status.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result. While out_tready is low a result is held and in_tready stays
//   low; a new request is taken in the same cycle a result leaves.
module due_date_priority_queue
  import ddpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // year[13:0] month[17:14] day[22:18] points[38:23] tag[46:39]
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // status[1:0] entry_count[6:2] year[20:7] month[24:21]
                                  // day[29:25] points[45:30] tag[53:46]
  output logic        out_tuser   // head_valid
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  entry_t entry_w [CAPACITY];
  logic   occ_w   [CAPACITY];
  logic   ge_w    [CAPACITY];

  entry_t     new_entry;
  cell_ctrl_t ctrl;
  logic       accept, full, empty;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             out_valid_r;

  out_data_t out_word;

  assign new_entry = entry_t'(in_tdata[46:0]);
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign full      = occ_w[CAPACITY-1];
  assign empty     = !occ_w[0];

  assign ctrl.enq = accept && (in_tuser == FUNC_ENQ) && !full;
  assign ctrl.deq = accept && (in_tuser == FUNC_DEQ) && !empty;

  // cell chain: left neighbor feeds inserts, right neighbor feeds pops
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_o, left_g, right_o;
    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_o = 1'b1;
      assign left_g = 1'b1;
    end else begin : g_mid
      assign left_e = entry_w[i-1];
      assign left_o = occ_w[i-1];
      assign left_g = ge_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
      assign right_o = 1'b0;
    end else begin : g_inner
      assign right_e = entry_w[i+1];
      assign right_o = occ_w[i+1];
    end
    ddpq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_occ    (left_o),
      .left_ge     (left_g),
      .right_entry (right_e),
      .right_occ   (right_o),
      .entry       (entry_w[i]),
      .occ         (occ_w[i]),
      .ge          (ge_w[i])
    );
  end

  // count and status of the request being taken
  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    if (accept) begin
      status_nxt = ST_OK;
      if (in_tuser == FUNC_ENQ) begin
        if (full) status_nxt = ST_FULL;
        else      count_nxt  = count_r + CNT_W'(1);
      end else begin
        if (empty) status_nxt = ST_EMPTY;
        else       count_nxt  = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  // head is read straight from cell 0, which only moves on a new request
  always_comb begin
    out_word        = '0;
    out_word.status = status_r;
    out_word.count  = COUNT_W'(count_r);
    out_word.head   = occ_w[0] ? entry_w[0] : '0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word;
  assign out_tuser  = occ_w[0];

endmodule

[rtl/ddpq_cell.sv]
// One slot of the sorted chain: holds an entry, shifts on insert or pop.
module ddpq_cell
  import ddpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  entry_t     left_entry,
  input  logic       left_occ,
  input  logic       left_ge,
  input  entry_t     right_entry,
  input  logic       right_occ,
  output entry_t     entry,
  output logic       occ,
  output logic       ge
);

  entry_t entry_r, entry_nxt;
  logic   occ_r, occ_nxt;

  // held entry ranks at least as high as the new one: new goes behind it
  assign ge = occ_r && !ranks_above(new_entry, entry_r);

  always_comb begin
    entry_nxt = entry_r;
    occ_nxt   = occ_r;
    if (ctrl.enq) begin
      occ_nxt = occ_r | left_occ;
      if (!ge) begin
        entry_nxt = left_ge ? new_entry : left_entry;
      end
    end else if (ctrl.deq) begin
      entry_nxt = right_entry;
      occ_nxt   = right_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign occ   = occ_r;

endmodule

[rtl/ddpq_checker.sv]
// Port-level checks on the due date priority queue, bound to its top level.
`include "due_date_priority_queue_defines.svh"

module ddpq_checker
  import ddpq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser
);

  out_data_t ow;
  logic      cnt_zero;
  logic      deq_take;

  assign ow       = out_data_t'(out_tdata);
  assign cnt_zero = (ow.count == '0);
  // dequeue request taken this cycle
  assign deq_take = in_tvalid && in_tready && (in_tuser == FUNC_DEQ);

  `DDPQ_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `DDPQ_ASSERT_NOW(a_empty_head, clk, rst_n, out_tvalid && !out_tuser, cnt_zero && ow.head == '0)
  `DDPQ_ASSERT_NOW(a_full_nonempty, clk, rst_n, out_tvalid && ow.status == ST_FULL, out_tuser)
  `DDPQ_ASSERT_NOW(a_deq_empty, clk, rst_n, out_tvalid && ow.status == ST_EMPTY, !out_tuser && cnt_zero)
  `DDPQ_ASSERT_NEXT(a_deq_status, clk, rst_n, deq_take, out_tvalid && ow.status != ST_FULL)

endmodule

bind due_date_priority_queue ddpq_checker u_ddpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
